// File: hdl/rhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the rgb/hsl color classifier.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int FREQ_BITS = 20;
	localparam int FRAC_BITS = 16;
	localparam int LEVEL_W   = FRAC_BITS + 1;
	localparam int HUE_W     = 13;
	localparam int CLS_W     = 3;
	localparam int ADDR_W    = 5;
	localparam int NUM_REGS  = 6;

	localparam logic [LEVEL_W-1:0] ONE_Q = LEVEL_W'(1) << FRAC_BITS;

	// hue scale: 60 degrees in sixteenths
	localparam int HUE_SECTOR = 960;
	localparam logic [HUE_W-1:0] HUE_BASE_R_NEG = HUE_W'(6 * HUE_SECTOR);
	localparam logic [HUE_W-1:0] HUE_BASE_G     = HUE_W'(2 * HUE_SECTOR);
	localparam logic [HUE_W-1:0] HUE_BASE_B     = HUE_W'(4 * HUE_SECTOR);

	// hue windows in sixteenths of a degree
	localparam logic [HUE_W-1:0] HUE_RED_HI   = HUE_W'(330 * 16);
	localparam logic [HUE_W-1:0] HUE_RED_LO   = HUE_W'(20 * 16);
	localparam logic [HUE_W-1:0] HUE_GREEN_LO = HUE_W'(80 * 16);
	localparam logic [HUE_W-1:0] HUE_GREEN_HI = HUE_W'(160 * 16);
	localparam logic [HUE_W-1:0] HUE_BLUE_LO  = HUE_W'(190 * 16);
	localparam logic [HUE_W-1:0] HUE_BLUE_HI  = HUE_W'(270 * 16);

	// register indexes
	localparam logic [2:0] REG_RED_BLACK   = 3'd0;
	localparam logic [2:0] REG_RED_WHITE   = 3'd1;
	localparam logic [2:0] REG_GREEN_BLACK = 3'd2;
	localparam logic [2:0] REG_GREEN_WHITE = 3'd3;
	localparam logic [2:0] REG_BLUE_BLACK  = 3'd4;
	localparam logic [2:0] REG_BLUE_WHITE  = 3'd5;

	typedef enum logic [CLS_W-1:0] {
		CLS_BLACK   = 3'd0,
		CLS_WHITE   = 3'd1,
		CLS_RED     = 3'd2,
		CLS_GREEN   = 3'd3,
		CLS_BLUE    = 3'd4,
		CLS_UNKNOWN = 3'd5
	} color_class_t;

	typedef struct packed {
		logic [FREQ_BITS-1:0] red_freq;
		logic [FREQ_BITS-1:0] green_freq;
		logic [FREQ_BITS-1:0] blue_freq;
	} in_t;

	typedef struct packed {
		logic [CLS_W-1:0]   color_class;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic [HUE_W-1:0]   hue_angle;
		logic [LEVEL_W-1:0] saturation;
		logic [LEVEL_W-1:0] lightness;
	} out_t;

	// one channel after the calibration compare
	typedef struct packed {
		logic                 zero;
		logic                 one;
		logic [FREQ_BITS-1:0] diff;
		logic [FREQ_BITS-1:0] span;
	} ch_prep_t;

	// travels alongside the saturation divider
	typedef struct packed {
		logic               valid;
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] b;
		logic [LEVEL_W-1:0] l;
	} sat_side_t;

	// travels alongside the hue divider
	typedef struct packed {
		logic             grey;
		logic             neg;
		logic [HUE_W-1:0] base;
	} hue_side_t;

	function automatic ch_prep_t norm_prep(input logic [FREQ_BITS-1:0] f,
			input logic [FREQ_BITS-1:0] blk, input logic [FREQ_BITS-1:0] wht);
		ch_prep_t p;
		if (wht > blk) begin
			p.zero = (f <= blk);
			p.one  = (f >= wht);
			p.diff = f - blk;
			p.span = wht - blk;
		end else begin
			p.zero = (f >= blk) || (wht == blk);
			p.one  = (f <= wht);
			p.diff = blk - f;
			p.span = blk - wht;
		end
		if (p.zero || p.one) begin
			p.diff = '0;
			p.span = FREQ_BITS'(1);
		end
		return p;
	endfunction

endpackage
`default_nettype wire

// File: hdl/rhc_pdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pdiv
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that moves in step. Requires num[NW-1:QW] < den.
// ----------------------------------------------------------------------------
module rhc_pdiv #(
	parameter int NW = 36,
	parameter int DW = 20,
	parameter int QW = 16,
	parameter int SW = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic      [QW-1:0] quo,
	output logic      [DW-1:0] rem,
	output logic      [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [1:QW];
	logic [QW-1:0] low_s  [1:QW];
	logic [QW-1:0] quo_s  [1:QW];
	logic [DW-1:0] den_s  [1:QW];
	logic [SW-1:0] side_s [1:QW];

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [QW-1:0] low_p;
		logic [QW-1:0] quo_p;
		logic [DW-1:0] den_p;
		logic [SW-1:0] side_p;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 1) begin : g_first
			assign rem_p  = DW'(num[NW-1:QW]);
			assign low_p  = num[QW-1:0];
			assign quo_p  = '0;
			assign den_p  = den;
			assign side_p = side_in;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign low_p  = low_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign trial = {rem_p, low_p[QW-1]};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (en) begin
				side_s[k] <= side_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
				low_s[k] <= {low_p[QW-2:0], 1'b0};
				quo_s[k] <= {quo_p[QW-2:0], ge};
				den_s[k] <= den_p;
			end
		end
	end

	assign quo      = quo_s[QW];
	assign rem      = rem_s[QW];
	assign side_out = side_s[QW];

endmodule
`default_nettype wire

// File: hdl/rgb_hsl_color_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_hsl_color_classifier_unit
// Normalizes an rgb frequency triple, converts it to hsl and names its color.
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid/in_ready/in_data carries one red, green, blue
//   frequency triple per transfer; output channel out_valid/out_ready/out_data
//   carries the class, the three levels, hue, saturation and lightness
// - six calibration registers (black and white frequency per color) sit on
//   the apb port at byte addresses 0, 4, .. 20; write them while idle
// - the path from input transfer to out_valid runs through one prep stage,
//   16 stages of the level dividers, two stages for max/min and divider
//   operands, 17 stages of the saturation and hue dividers, one hue/saturation
//   fix-up stage and the output register
// - throughput is one triple per cycle while in_ready is high; each divider
//   stage resolves one quotient bit, so a new triple can enter every cycle
// - when out_ready is low with a result held, the whole pipeline freezes
//   and in_ready drops; nothing is lost or repeated
// - reset clears the calibration registers to zero and empties the pipeline
// ----------------------------------------------------------------------------
module rgb_hsl_color_classifier_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rhc_pkg::in_t                in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output rhc_pkg::out_t                    out_data,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rhc_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);

	localparam int FB = rhc_pkg::FREQ_BITS;
	localparam int F  = rhc_pkg::FRAC_BITS;
	localparam int LW = rhc_pkg::LEVEL_W;
	localparam int HW = rhc_pkg::HUE_W;
	localparam int HNW = F + 11;

	// ---------------- configuration ----------------
	logic [FB-1:0] cal_q [0:rhc_pkg::NUM_REGS-1];
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rhc_pkg::NUM_REGS; i++) cal_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				rhc_pkg::REG_RED_BLACK:   cal_q[0] <= pwdata[FB-1:0];
				rhc_pkg::REG_RED_WHITE:   cal_q[1] <= pwdata[FB-1:0];
				rhc_pkg::REG_GREEN_BLACK: cal_q[2] <= pwdata[FB-1:0];
				rhc_pkg::REG_GREEN_WHITE: cal_q[3] <= pwdata[FB-1:0];
				rhc_pkg::REG_BLUE_BLACK:  cal_q[4] <= pwdata[FB-1:0];
				rhc_pkg::REG_BLUE_WHITE:  cal_q[5] <= pwdata[FB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rhc_pkg::REG_RED_BLACK:   prdata = 32'(cal_q[0]);
			rhc_pkg::REG_RED_WHITE:   prdata = 32'(cal_q[1]);
			rhc_pkg::REG_GREEN_BLACK: prdata = 32'(cal_q[2]);
			rhc_pkg::REG_GREEN_WHITE: prdata = 32'(cal_q[3]);
			rhc_pkg::REG_BLUE_BLACK:  prdata = 32'(cal_q[4]);
			rhc_pkg::REG_BLUE_WHITE:  prdata = 32'(cal_q[5]);
			default:                  prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic          en;
	logic          out_valid_q;
	rhc_pkg::out_t out_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- stage 1: calibration compare ----------------
	logic              valid_s1;
	rhc_pkg::ch_prep_t red_s1, green_s1, blue_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1   <= rhc_pkg::norm_prep(in_data.red_freq, cal_q[0], cal_q[1]);
			green_s1 <= rhc_pkg::norm_prep(in_data.green_freq, cal_q[2], cal_q[3]);
			blue_s1  <= rhc_pkg::norm_prep(in_data.blue_freq, cal_q[4], cal_q[5]);
		end
	end

	// ---------------- level dividers ----------------
	logic [F-1:0]  rq, gq, bq;
	logic [FB-1:0] rr, gr, br;
	logic [2:0]    rside;
	logic [1:0]    gside, bside;

	rhc_pdiv #(.NW(FB + F), .DW(FB), .QW(F), .SW(3)) u_div_red (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({red_s1.diff, {F{1'b0}}}), .den(red_s1.span),
		.side_in({valid_s1, red_s1.zero, red_s1.one}),
		.quo(rq), .rem(rr), .side_out(rside)
	);

	rhc_pdiv #(.NW(FB + F), .DW(FB), .QW(F), .SW(2)) u_div_green (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({green_s1.diff, {F{1'b0}}}), .den(green_s1.span),
		.side_in({green_s1.zero, green_s1.one}),
		.quo(gq), .rem(gr), .side_out(gside)
	);

	rhc_pdiv #(.NW(FB + F), .DW(FB), .QW(F), .SW(2)) u_div_blue (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num({blue_s1.diff, {F{1'b0}}}), .den(blue_s1.span),
		.side_in({blue_s1.zero, blue_s1.one}),
		.quo(bq), .rem(br), .side_out(bside)
	);

	// ---------------- stage 2: levels, max and min ----------------
	logic [LW-1:0] r_c, g_c, b_c, mx_c, mn_c;
	logic          valid_s2, max_r_s2, max_g_s2;
	logic [LW-1:0] r_s2, g_s2, b_s2, mx_s2, mn_s2;

	always_comb begin
		// zero wins: an equal calibration pair can flag both
		r_c = rside[1] ? '0 : (rside[0] ? rhc_pkg::ONE_Q : {1'b0, rq});
		g_c = gside[1] ? '0 : (gside[0] ? rhc_pkg::ONE_Q : {1'b0, gq});
		b_c = bside[1] ? '0 : (bside[0] ? rhc_pkg::ONE_Q : {1'b0, bq});
		mx_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		mn_c = r_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= rside[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2     <= r_c;
			g_s2     <= g_c;
			b_s2     <= b_c;
			mx_s2    <= mx_c;
			mn_s2    <= mn_c;
			max_r_s2 <= (mx_c == r_c);
			max_g_s2 <= (mx_c == g_c);
		end
	end

	// ---------------- stage 3: divider operands ----------------
	logic [LW-1:0]  delta_c, hue_a_c, hue_b_c, hdiff_c;
	logic [LW:0]    sum_c;
	logic [LW-1:0]  sden_c;
	logic [HW-1:0]  base_c;
	logic           grey_c;

	logic              valid_s3;
	logic [2*F:0]      snum_s3;
	logic [LW-1:0]     sden_s3;
	logic [HNW-1:0]    hnum_s3;
	logic [LW-1:0]     hden_s3;
	rhc_pkg::sat_side_t sside_s3;
	rhc_pkg::hue_side_t hside_s3;

	always_comb begin
		delta_c = mx_s2 - mn_s2;
		sum_c   = {1'b0, mx_s2} + {1'b0, mn_s2};
		grey_c  = (delta_c == '0);
		if (sum_c > {1'b0, rhc_pkg::ONE_Q}) begin
			sden_c = LW'({rhc_pkg::ONE_Q, 1'b0} - sum_c);
		end else begin
			sden_c = sum_c[LW-1:0];
		end
		if (max_r_s2) begin
			hue_a_c = g_s2;
			hue_b_c = b_s2;
			base_c  = (g_s2 >= b_s2) ? '0 : rhc_pkg::HUE_BASE_R_NEG;
		end else if (max_g_s2) begin
			hue_a_c = b_s2;
			hue_b_c = r_s2;
			base_c  = rhc_pkg::HUE_BASE_G;
		end else begin
			hue_a_c = r_s2;
			hue_b_c = g_s2;
			base_c  = rhc_pkg::HUE_BASE_B;
		end
		hdiff_c = (hue_a_c >= hue_b_c) ? hue_a_c - hue_b_c : hue_b_c - hue_a_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// grey input: feed 0/1 so both dividers stay in range
			snum_s3 <= grey_c ? '0 : {delta_c, {F{1'b0}}};
			sden_s3 <= grey_c ? LW'(1) : sden_c;
			// times 960 as 1024 - 64
			hnum_s3 <= grey_c ? '0 :
				(HNW'(hdiff_c) << 10) - (HNW'(hdiff_c) << 6);
			hden_s3 <= grey_c ? LW'(1) : delta_c;
			sside_s3.r <= r_s2;
			sside_s3.g <= g_s2;
			sside_s3.b <= b_s2;
			sside_s3.l <= sum_c[LW:1];
			sside_s3.valid <= 1'b0;
			hside_s3.grey <= grey_c;
			hside_s3.neg  <= (hue_a_c < hue_b_c);
			hside_s3.base <= base_c;
		end
	end

	rhc_pkg::sat_side_t sside_in, sside_out;
	rhc_pkg::hue_side_t hside_out;
	logic [LW-1:0] squo, srem, hquo, hrem;

	always_comb begin
		sside_in       = sside_s3;
		sside_in.valid = valid_s3;
	end

	rhc_pdiv #(.NW(2 * F + 1), .DW(LW), .QW(LW), .SW($bits(rhc_pkg::sat_side_t))) u_div_sat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(snum_s3), .den(sden_s3), .side_in(sside_in),
		.quo(squo), .rem(srem), .side_out(sside_out)
	);

	rhc_pdiv #(.NW(HNW), .DW(LW), .QW(LW), .SW($bits(rhc_pkg::hue_side_t))) u_div_hue (
		.clk(clk), .arst_n(arst_n), .en(en),
		.num(hnum_s3), .den(hden_s3), .side_in(hside_s3),
		.quo(hquo), .rem(hrem), .side_out(hside_out)
	);

	// ---------------- stage 4: hue and saturation ----------------
	logic [HW-1:0] hue_c;
	logic          valid_s4;
	logic [LW-1:0] r_s4, g_s4, b_s4, l_s4, s_s4;
	logic [HW-1:0] h_s4;

	always_comb begin
		if (hside_out.grey) begin
			hue_c = '0;
		end else if (hside_out.neg) begin
			// floor of a negative fraction rounds the quotient up
			hue_c = hside_out.base - hquo[HW-1:0] - HW'(hrem != '0);
		end else begin
			hue_c = hside_out.base + hquo[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sside_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4 <= sside_out.r;
			g_s4 <= sside_out.g;
			b_s4 <= sside_out.b;
			l_s4 <= sside_out.l;
			s_s4 <= hside_out.grey ? '0 : squo;
			h_s4 <= hue_c;
		end
	end

	// ---------------- stage 5: classification ----------------
	rhc_pkg::color_class_t cls_c;
	logic [31:0] l_w, s_w;

	always_comb begin
		l_w = 32'(l_s4);
		s_w = 32'(s_s4);
		if (l_w * 32'd100 < 32'd15 * 32'(rhc_pkg::ONE_Q)) begin
			cls_c = rhc_pkg::CLS_BLACK;
		end else if (l_w * 32'd4 > 32'd3 * 32'(rhc_pkg::ONE_Q)
				&& s_w * 32'd10 < 32'd3 * 32'(rhc_pkg::ONE_Q)) begin
			cls_c = rhc_pkg::CLS_WHITE;
		end else if (h_s4 >= rhc_pkg::HUE_RED_HI || h_s4 < rhc_pkg::HUE_RED_LO) begin
			cls_c = rhc_pkg::CLS_RED;
		end else if (h_s4 >= rhc_pkg::HUE_GREEN_LO && h_s4 < rhc_pkg::HUE_GREEN_HI) begin
			cls_c = rhc_pkg::CLS_GREEN;
		end else if (h_s4 >= rhc_pkg::HUE_BLUE_LO && h_s4 < rhc_pkg::HUE_BLUE_HI) begin
			cls_c = rhc_pkg::CLS_BLUE;
		end else if (s_w * 32'd5 < 32'(rhc_pkg::ONE_Q)) begin
			cls_c = (l_w * 32'd2 < 32'(rhc_pkg::ONE_Q)) ?
				rhc_pkg::CLS_BLACK : rhc_pkg::CLS_WHITE;
		end else begin
			cls_c = rhc_pkg::CLS_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.color_class <= cls_c;
			out_q.red_level   <= r_s4;
			out_q.green_level <= g_s4;
			out_q.blue_level  <= b_s4;
			out_q.hue_angle   <= h_s4;
			out_q.saturation  <= s_s4;
			out_q.lightness   <= l_s4;
		end
	end

	// unused remainders of the level and saturation dividers
	logic unused_rem;
	assign unused_rem = ^{rr, gr, br, srem};

endmodule
`default_nettype wire
